@@ src/axle_counter_beam_qualifier_macros.svh @@
// Assertion macros for the axle counter beam qualifier.
// Used by axle_counter_beam_qualifier.sv; expects i_clk and i_rst_n in scope.
`ifndef AXLE_COUNTER_BEAM_QUALIFIER_MACROS_SVH
`define AXLE_COUNTER_BEAM_QUALIFIER_MACROS_SVH

// Same-cycle implication, quiet during reset
`define ACBQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset
`define ACBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/acbq_pkg.sv @@
// Types and codes for the axle counter beam qualifier.
// No dependencies; used by axle_counter_beam_qualifier.sv.
`timescale 1ns / 1ps

package acbq_pkg;

    // Input word kind
    typedef enum logic [1:0] {
        FN_TICK     = 2'd0,
        FN_BROKEN   = 2'd1,
        FN_RESTORED = 2'd2
    } t_func;

    // Pass-by mode machine
    typedef enum logic [2:0] {
        M_READY = 3'd0,
        M_WOFF  = 3'd1,
        M_WON   = 3'd2,
        M_ERROR = 3'd3,
        M_IDLE  = 3'd4,
        M_SLEEP = 3'd5
    } t_mode;

    // Wheel qualifier state
    typedef enum logic [2:0] {
        W_OFF      = 3'd0,
        W_LEAVING  = 3'd1,
        W_ENTERING = 3'd2,
        W_ON       = 3'd3,
        W_TOOLONG  = 3'd4
    } t_wheel;

    // Reported event
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_START = 3'd1,
        EV_AXLE  = 3'd2,
        EV_STOP  = 3'd3,
        EV_ERROR = 3'd4
    } t_event;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENTER_DWELL = 2'd0,
        CFG_LEAVE_DWELL = 2'd1,
        CFG_MAX_BLOCK   = 2'd2,
        CFG_PASS_END    = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] ENTER_DWELL_RST = 16'd3;
    localparam logic [15:0] LEAVE_DWELL_RST = 16'd3;
    localparam logic [15:0] MAX_BLOCK_RST   = 16'd1000;
    localparam logic [15:0] PASS_END_RST    = 16'd3000;

    // Time base width: low 17 bits are enough for the midpoint and stop time
    localparam int TimeW = 17;

    // One result word
    typedef struct packed {
        logic        power;
        t_wheel      wheel;
        t_mode       mode;
        logic [15:0] event_time;
        logic [15:0] axles_seen;
        logic [15:0] pass_count;
        t_event      event_kind;
    } t_result;

endpackage

@@ src/axle_counter_beam_qualifier.sv @@
// A result word is registered at the edge that accepts its input word, into the output
// register if that is empty or being taken, else into the skid stage. One word per clock is
// accepted while the skid stage is empty. The output register plus a one-word skid stage keep
// the slave side open for one more word while a result waits. Reset (i_rst_n low, synchronous)
// clears control state and valid flags, restores register defaults; mode starts idle, sensor off.
// Axle counter beam qualifier: wheel debounce, pass-by mode machine, event output.
// Depends on acbq_pkg and axle_counter_beam_qualifier_macros.svh.
`timescale 1ns / 1ps

`include "axle_counter_beam_qualifier_macros.svh"

module axle_counter_beam_qualifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [0] arm_pin, [1] wake_pin, [2] force_pin, rest zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] func
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [15:0] pass_count, [31:16] axles_seen,
                                       // [47:32] event_time, [50:48] mode, [53:51] wheel,
                                       // [54] sensor_power, [55] zero
    output logic [2:0]  m_axis_tuser   // [2:0] event_kind
);

    localparam int TW = acbq_pkg::TimeW;

    // configuration
    logic [15:0] r_enter_dwell, r_leave_dwell, r_max_block, r_pass_end;

    // qualifier and mode state
    acbq_pkg::t_mode  r_mode,  n_mode;
    acbq_pkg::t_wheel r_wheel, n_wheel;
    logic [15:0]      r_left,  n_left;
    logic             r_run,   n_run;
    logic             r_over,  n_over;
    logic [15:0]      r_pass,  n_pass;
    logic [15:0]      r_axles, n_axles;
    logic [TW-1:0]    r_now,   n_now;
    logic [TW-1:0]    r_enter, n_enter;
    logic [TW-1:0]    r_leave, n_leave;
    logic             r_power, n_power;

    // output register and skid stage
    acbq_pkg::t_result r_out, r_skid, res;
    logic              r_out_valid, r_skid_valid;

    acbq_pkg::t_func   func;
    acbq_pkg::t_event  ev;
    logic [15:0]       ev_time;
    logic [TW:0]       mid_sum;
    logic              arm, wake, force_p;
    logic              accept, take;

    assign func    = acbq_pkg::t_func'(s_axis_tuser);
    assign arm     = s_axis_tdata[0];
    assign wake    = s_axis_tdata[1];
    assign force_p = s_axis_tdata[2];

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = r_out_valid && m_axis_tready;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_dwell <= acbq_pkg::ENTER_DWELL_RST;
            r_leave_dwell <= acbq_pkg::LEAVE_DWELL_RST;
            r_max_block   <= acbq_pkg::MAX_BLOCK_RST;
            r_pass_end    <= acbq_pkg::PASS_END_RST;
        end else if (i_cfg_we) begin
            unique case (acbq_pkg::t_cfg_idx'(i_cfg_addr))
                acbq_pkg::CFG_ENTER_DWELL: r_enter_dwell <= i_cfg_wdata;
                acbq_pkg::CFG_LEAVE_DWELL: r_leave_dwell <= i_cfg_wdata;
                acbq_pkg::CFG_MAX_BLOCK:   r_max_block   <= i_cfg_wdata;
                acbq_pkg::CFG_PASS_END:    r_pass_end    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // wheel qualifier, then mode machine on the updated wheel
    always_comb begin
        n_mode  = r_mode;
        n_wheel = r_wheel;
        n_left  = r_left;
        n_run   = r_run;
        n_over  = r_over;
        n_pass  = r_pass;
        n_axles = r_axles;
        n_now   = r_now;
        n_enter = r_enter;
        n_leave = r_leave;
        n_power = r_power;
        ev      = acbq_pkg::EV_NONE;
        ev_time = '0;
        mid_sum = {1'b0, r_enter} + {1'b0, r_leave};

        unique case (func)
            acbq_pkg::FN_TICK: begin
                n_now = r_now + TW'(1);
                // count the timeout down; fire on the tick that reaches zero
                if (r_power && r_run) begin
                    if (r_left <= 16'd1) begin
                        n_left = '0;
                        n_run  = 1'b0;
                        unique case (r_wheel)
                            acbq_pkg::W_OFF: n_over = 1'b1;
                            acbq_pkg::W_LEAVING: begin
                                n_wheel = acbq_pkg::W_OFF;
                                n_left  = r_pass_end;
                                n_run   = 1'b1;
                            end
                            acbq_pkg::W_ON: n_wheel = acbq_pkg::W_TOOLONG;
                            acbq_pkg::W_ENTERING: begin
                                n_wheel = acbq_pkg::W_ON;
                                n_left  = r_max_block;
                                n_run   = 1'b1;
                            end
                            default: ;
                        endcase
                    end else begin
                        n_left = r_left - 16'd1;
                    end
                end
            end
            acbq_pkg::FN_BROKEN: begin
                if (r_power) begin
                    n_run = 1'b0;
                    if (r_wheel == acbq_pkg::W_OFF) begin
                        n_wheel = acbq_pkg::W_ENTERING;
                        n_left  = r_enter_dwell;
                        n_run   = 1'b1;
                        // first wheel of a pass restarts the time base
                        if (r_mode == acbq_pkg::M_READY) begin
                            n_now = '0;
                        end
                        n_enter = n_now;
                    end else if (r_wheel == acbq_pkg::W_LEAVING) begin
                        n_wheel = acbq_pkg::W_ON;
                    end
                end
            end
            acbq_pkg::FN_RESTORED: begin
                if (r_power) begin
                    n_run = 1'b0;
                    if (r_wheel == acbq_pkg::W_ENTERING) begin
                        n_wheel = acbq_pkg::W_OFF;
                    end else if (r_wheel == acbq_pkg::W_ON) begin
                        n_wheel = acbq_pkg::W_LEAVING;
                        n_left  = r_leave_dwell;
                        n_run   = 1'b1;
                        n_leave = r_now;
                    end else if (r_wheel == acbq_pkg::W_TOOLONG) begin
                        n_wheel = acbq_pkg::W_OFF;
                    end
                end
            end
            default: ;
        endcase

        // the midpoint uses this word's latched times
        mid_sum = {1'b0, n_enter} + {1'b0, n_leave};

        unique case (r_mode)
            acbq_pkg::M_SLEEP: begin
                if (wake || force_p) begin
                    n_mode = acbq_pkg::M_IDLE;
                end
            end
            acbq_pkg::M_IDLE: begin
                if (arm || force_p) begin
                    n_mode  = acbq_pkg::M_READY;
                    n_run   = 1'b0;
                    n_left  = '0;
                    n_power = 1'b1;
                end else if (!wake) begin
                    n_mode = acbq_pkg::M_SLEEP;
                end
            end
            acbq_pkg::M_READY: begin
                if (n_wheel == acbq_pkg::W_ON) begin
                    n_mode = acbq_pkg::M_WON;
                end else if (n_wheel == acbq_pkg::W_ENTERING) begin
                    n_mode = acbq_pkg::M_READY;
                end else if (!arm && !force_p) begin
                    n_mode  = acbq_pkg::M_IDLE;
                    n_power = 1'b0;
                end
            end
            acbq_pkg::M_WON: begin
                if (n_wheel == acbq_pkg::W_OFF) begin
                    if (r_axles == 16'd0) begin
                        n_pass  = r_pass + 16'd1;
                        n_axles = 16'd1;
                        ev      = acbq_pkg::EV_START;
                    end else begin
                        n_axles = r_axles + 16'd1;
                        ev      = acbq_pkg::EV_AXLE;
                        ev_time = mid_sum[16:1];
                    end
                    n_mode = acbq_pkg::M_WOFF;
                end else if (n_wheel == acbq_pkg::W_TOOLONG) begin
                    n_mode = acbq_pkg::M_ERROR;
                    ev     = acbq_pkg::EV_ERROR;
                end
            end
            acbq_pkg::M_WOFF: begin
                if (n_wheel == acbq_pkg::W_ON) begin
                    n_mode = acbq_pkg::M_WON;
                end else if (n_over) begin
                    n_over  = 1'b0;
                    ev      = acbq_pkg::EV_STOP;
                    ev_time = n_now[15:0];
                    n_mode  = acbq_pkg::M_READY;
                    n_run   = 1'b0;
                    n_left  = '0;
                    n_axles = '0;
                end
            end
            acbq_pkg::M_ERROR: begin
                if (n_wheel == acbq_pkg::W_OFF) begin
                    n_mode  = acbq_pkg::M_READY;
                    n_run   = 1'b0;
                    n_left  = '0;
                    n_axles = '0;
                end
            end
            default: n_mode = acbq_pkg::M_IDLE;
        endcase

        res.power      = n_power;
        res.wheel      = n_wheel;
        res.mode       = n_mode;
        res.event_time = ev_time;
        res.axles_seen = n_axles;
        res.pass_count = n_pass;
        res.event_kind = ev;
    end

    // advance state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= acbq_pkg::M_IDLE;
            r_wheel <= acbq_pkg::W_OFF;
            r_left  <= '0;
            r_run   <= 1'b0;
            r_over  <= 1'b0;
            r_pass  <= '0;
            r_axles <= '0;
            r_now   <= '0;
            r_enter <= '0;
            r_leave <= '0;
            r_power <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_wheel <= n_wheel;
            r_left  <= n_left;
            r_run   <= n_run;
            r_over  <= n_over;
            r_pass  <= n_pass;
            r_axles <= n_axles;
            r_now   <= n_now;
            r_enter <= n_enter;
            r_leave <= n_leave;
            r_power <= n_power;
        end
    end

    // output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.event_kind;
    assign m_axis_tdata  = {1'b0, r_out.power, r_out.wheel, r_out.mode,
                            r_out.event_time, r_out.axles_seen, r_out.pass_count};

    // sensor is powered exactly in the active modes
    `ACBQ_ASSERT_NOW(a_power_mode, 1'b1, r_power == ((r_mode != acbq_pkg::M_IDLE) && (r_mode != acbq_pkg::M_SLEEP)), "sensor power disagrees with mode")
    // skid holds a word only behind a full output register
    `ACBQ_ASSERT_NOW(a_skid_order, r_skid_valid, r_out_valid, "skid word without output word")
    // a pass start always reports the first axle with the wheel gone
    `ACBQ_ASSERT_NEXT(a_start_word, accept && (ev == acbq_pkg::EV_START), (r_axles == 16'd1) && (r_mode == acbq_pkg::M_WOFF), "pass start with wrong axle count or mode")

endmodule
